@@ design/sbda_pkg.sv @@
// shared constants, types and sizing for the signed binary to decimal ascii converter
package sbda_pkg;

   // width of the signed input value
   localparam int VALUE_BITS = 32;

   // input beat is padded up to whole bytes
   localparam int REQ_DATA_W = ((VALUE_BITS + 7) / 8) * 8;

   // output character width
   localparam int CHAR_W = 8;

   // ascii codes
   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

   // decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1)
   function automatic int calc_digits(int bits);
      longint unsigned mag;
      int              count;
      int              i;
      mag   = 64'd1 << (bits - 1);
      count = 0;
      for (i = 0; i < 24; i++) begin
         if (mag != 64'd0) begin
            count = count + 1;
            mag   = mag / 10;
         end
      end
      return count;
   endfunction

   localparam int DIGITS = calc_digits(VALUE_BITS);
   localparam int BCD_W  = DIGITS * 4;
   localparam int PTR_W  = $clog2(DIGITS);
   localparam int CNT_W  = $clog2(VALUE_BITS);

   // controller to datapath commands
   typedef struct packed {
      logic load;        // capture a new input value
      logic shift;       // one double-dabble step
      logic set_ptr;     // point at the leading nonzero digit
      logic emit_sign;   // load a minus sign into the output register
      logic emit_digit;  // load the pointed digit into the output register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic negative;    // captured value was negative
      logic last_digit;  // digit pointer sits on the units digit
      logic out_free;    // output register can take a character this cycle
   } status_type;

endpackage

@@ design/signed_binary_to_decimal_ascii.sv @@
// top level of the signed binary to decimal ascii converter
//
// Converts one signed two's complement value per input beat into its decimal
// text, one ascii character per output beat, most significant first. A minus
// sign leads negative values, leading zeros are dropped, zero gives "0", and
// the most negative value converts exactly. rsp_tlast marks the final digit.
//
// req channel: tdata holds the value. rsp channel: tdata holds the character,
// tlast the end of the number.
// Timing: after an input beat is taken, a shift-and-add-3 unit runs one bit
// per cycle, a prepare step finds the leading digit, then one character is
// loaded into the output register per cycle while the receiver takes them.
// A number has 1 to 11 characters, and req_tready returns the cycle after
// its last character is loaded, so a new value is only taken once the
// previous one is fully loaded. The bit-serial conversion loop sets the pace.
// When the receiver stalls, the output register holds its beat and the
// character sequencing waits. Reset empties the output register and returns
// the controller to idle, ready for a new value.
module signed_binary_to_decimal_ascii (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sbda_pkg::REQ_DATA_W-1:0] req_tdata,   // [31:0] value (signed)
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sbda_pkg::CHAR_W-1:0]     rsp_tdata,   // [7:0] char_code
   output logic                            rsp_tlast    // last_char
);

   sbda_pkg::cmd_type    cmd;
   sbda_pkg::status_type status;

   // sequencer
   sbda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // conversion datapath
   sbda_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ design/sbda_dp.sv @@
// datapath: magnitude, bcd conversion register, digit pointer and output register
module sbda_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [sbda_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  sbda_pkg::cmd_type                 cmd,
   output sbda_pkg::status_type              status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sbda_pkg::CHAR_W-1:0]       rsp_tdata,
   output logic                              rsp_tlast
);

   logic [sbda_pkg::VALUE_BITS-1:0] raw;
   logic                            negative_ff, negative_in;
   logic [sbda_pkg::VALUE_BITS-1:0] mag_ff, mag_in;
   logic [sbda_pkg::BCD_W-1:0]      bcd_ff, bcd_in;
   logic [sbda_pkg::BCD_W-1:0]      bcd_adj;
   logic [sbda_pkg::PTR_W-1:0]      ptr_ff, ptr_in;
   logic [sbda_pkg::PTR_W-1:0]      lead;
   logic [3:0]                      digit_sel;
   logic                            valid_ff, valid_in;
   logic [sbda_pkg::CHAR_W-1:0]     char_ff, char_in;
   logic                            last_ff, last_in;

   assign raw = req_tdata[sbda_pkg::VALUE_BITS-1:0];

   // add-3 correction of every bcd digit ahead of the shift
   always_comb begin
      for (int i = 0; i < sbda_pkg::DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   // leading nonzero digit, units digit when all are zero
   always_comb begin
      lead = '0;
      for (int i = 0; i < sbda_pkg::DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) begin
            lead = sbda_pkg::PTR_W'(i);
         end
      end
   end

   // magnitude and bcd register update
   always_comb begin
      negative_in = negative_ff;
      mag_in      = mag_ff;
      bcd_in      = bcd_ff;
      if (cmd.load) begin
         negative_in = raw[sbda_pkg::VALUE_BITS-1];
         mag_in      = raw[sbda_pkg::VALUE_BITS-1] ? (~raw + 1'b1) : raw;
         bcd_in      = '0;
      end else if (cmd.shift) begin
         bcd_in = {bcd_adj[sbda_pkg::BCD_W-2:0], mag_ff[sbda_pkg::VALUE_BITS-1]};
         mag_in = {mag_ff[sbda_pkg::VALUE_BITS-2:0], 1'b0};
      end
   end

   // digit pointer walks from the leading digit down to the units
   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.set_ptr) begin
         ptr_in = lead;
      end else if (cmd.emit_digit) begin
         ptr_in = ptr_ff - 1'b1;
      end
   end

   assign digit_sel = bcd_ff[ptr_ff*4 +: 4];

   // output register, refilled when empty or being taken
   always_comb begin
      char_in  = char_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_tready;
      if (cmd.emit_sign) begin
         char_in  = sbda_pkg::ASCII_MINUS;
         last_in  = 1'b0;
         valid_in = 1'b1;
      end else if (cmd.emit_digit) begin
         char_in  = sbda_pkg::ASCII_ZERO + {4'd0, digit_sel};
         last_in  = (ptr_ff == '0);
         valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      negative_ff <= negative_in;
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      ptr_ff      <= ptr_in;
      char_ff     <= char_in;
      last_ff     <= last_in;
   end

   assign status.negative   = negative_ff;
   assign status.last_digit = (ptr_ff == '0);
   assign status.out_free   = !valid_ff || rsp_tready;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;

endmodule

@@ design/sbda_ctrl.sv @@
// controller: sequences capture, bit-serial conversion and character output
module sbda_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  sbda_pkg::status_type status,
   output sbda_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_PREP = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic [sbda_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = sbda_pkg::CNT_W'(sbda_pkg::VALUE_BITS - 1);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.shift = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_PREP;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_PREP: begin
            cmd.set_ptr = 1'b1;
            state_in    = status.negative ? ST_SIGN : ST_EMIT;
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

@@ design/sbda_chk.sv @@
// port-level checker for the signed binary to decimal ascii converter
module sbda_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [sbda_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sbda_pkg::CHAR_W-1:0]     rsp_tdata,
   input logic                            rsp_tlast
);

   // a stalled output beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled output beat changed");

   // only a minus sign or a decimal digit is ever sent
   a_char_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == sbda_pkg::ASCII_MINUS) ||
         ((rsp_tdata >= sbda_pkg::ASCII_ZERO) && (rsp_tdata <= 8'h39)))
      else $error("output beat is not a minus sign or digit");

   // a minus sign is always followed by digits
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata == sbda_pkg::ASCII_MINUS) |-> !rsp_tlast)
      else $error("minus sign flagged as last character");

   // one value at a time: input closes after a beat is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input still open right after taking a value");

endmodule

bind signed_binary_to_decimal_ascii sbda_chk u_sbda_chk (.*);

@@ dv/sbda_text_checker.sv @@
// watches both channels of the decimal text converter, predicts each number's characters and compares
`timescale 1ns / 1ps

module sbda_text_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [sbda_pkg::REQ_DATA_W-1:0] req_tdata,    // [31:0] value (signed)
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [sbda_pkg::CHAR_W-1:0]     rsp_tdata,    // [7:0] char_code
   input  logic                            rsp_tlast,    // last_char
   output int                              chars_pending,
   output int                              fail_count
);

   localparam int VALUE_BITS = sbda_pkg::VALUE_BITS;
   localparam int REQ_DATA_W = sbda_pkg::REQ_DATA_W;
   localparam int CHAR_W     = sbda_pkg::CHAR_W;

   // one expected character of the decimal text
   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              is_last;
   } char_beat_type;

   char_beat_type expected_text[$];

   initial begin
      fail_count    = 0;
      chars_pending = 0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count = fail_count + 1;
   endtask

   // decimal text of one value: optional minus, then digits most significant first
   function automatic void predict_text(input logic [REQ_DATA_W-1:0] word);
      logic [VALUE_BITS-1:0] raw;
      logic [VALUE_BITS-1:0] magnitude;
      logic [CHAR_W-1:0]     text[$];
      char_beat_type         beat;
      logic                  negative;
      raw       = word[VALUE_BITS-1:0];
      negative  = raw[VALUE_BITS-1];
      // unsigned magnitude, exact for the most negative value
      magnitude = negative ? (~raw + 1'b1) : raw;
      do begin
         text.push_front(sbda_pkg::ASCII_ZERO + CHAR_W'(magnitude % 10));
         magnitude = magnitude / 10;
      end while (magnitude != '0);
      if (negative) begin
         text.push_front(sbda_pkg::ASCII_MINUS);
      end
      foreach (text[i]) begin
         beat.code    = text[i];
         beat.is_last = (i == text.size() - 1);
         expected_text.push_back(beat);
      end
   endfunction

   // input beats feed the predictor, output beats are compared in order
   always @(posedge clock) begin
      char_beat_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_text(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_text.size() == 0) begin
               report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               want = expected_text.pop_front();
               if (rsp_tdata !== want.code)
                  report_mismatch($sformatf("char_code got 0x%02h want 0x%02h",
                                            rsp_tdata, want.code));
               if (rsp_tlast !== want.is_last)
                  report_mismatch($sformatf("last_char got %0b want %0b on char 0x%02h",
                                            rsp_tlast, want.is_last, want.code));
            end
         end
      end
      chars_pending = expected_text.size();
   end

endmodule

@@ dv/tb_signed_binary_to_decimal_ascii.sv @@
// top of the decimal text converter testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_signed_binary_to_decimal_ascii;

   localparam int VALUE_BITS    = sbda_pkg::VALUE_BITS;
   localparam int REQ_DATA_W    = sbda_pkg::REQ_DATA_W;
   localparam int CHAR_W        = sbda_pkg::CHAR_W;

   localparam int RANDOM_VALUES = 80;
   localparam int IDLE_PERCENT  = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 60;

   localparam logic [VALUE_BITS-1:0] MOST_NEGATIVE = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic [VALUE_BITS-1:0] MOST_POSITIVE = ~MOST_NEGATIVE;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [CHAR_W-1:0]     rsp_tdata;
   logic                  rsp_tlast;
   logic                  no_idle    = 1'b0;
   int                    chars_pending;
   int                    fail_count;
   int                    quiet_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   signed_binary_to_decimal_ascii dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   sbda_text_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .chars_pending (chars_pending),
      .fail_count    (fail_count)
   );

   // receiver stalls now and then, never during the quiet stretch
   always @(posedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // present one value, with random gaps ahead of it, and wait for the beat
   task automatic send_value(input logic [VALUE_BITS-1:0] value);
      logic [REQ_DATA_W-1:0] word;
      logic                  taken;
      while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      // bits above the value, if any, carry noise
      word                   = REQ_DATA_W'({$urandom(), $urandom()});
      word[VALUE_BITS-1:0]   = value;
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
   endtask

   // random value spread over all magnitudes and both signs
   function automatic logic [VALUE_BITS-1:0] random_value();
      logic [VALUE_BITS-1:0] value;
      int                    bits;
      value = VALUE_BITS'({$urandom(), $urandom()});
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: value = '0;
               1: value = MOST_NEGATIVE;
               2: value = MOST_POSITIVE;
               3: value = '1;
               default: value = VALUE_BITS'(1);
            endcase
         end
         1, 2: begin
            // full width, any sign
         end
         default: begin
            bits  = $urandom_range(1, VALUE_BITS - 1);
            value = value >> (VALUE_BITS - bits);
            if ($urandom_range(0, 1) == 1)
               value = -value;
         end
      endcase
      return value;
   endfunction

   initial begin
      logic [VALUE_BITS-1:0] directed[$];
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // zero, extremes, digit-count boundaries and alternating bit patterns
      directed = '{'0, VALUE_BITS'(1), '1, VALUE_BITS'(9), VALUE_BITS'(10),
                   VALUE_BITS'(-10), VALUE_BITS'(99), VALUE_BITS'(100),
                   MOST_POSITIVE, MOST_NEGATIVE, MOST_NEGATIVE + 1'b1,
                   MOST_POSITIVE - 1'b1, VALUE_BITS'(1000000000),
                   VALUE_BITS'(999999999), VALUE_BITS'(-999999999),
                   VALUE_BITS'(-1000000000), VALUE_BITS'(12345), VALUE_BITS'(-7),
                   {(VALUE_BITS/2){2'b01}}, {(VALUE_BITS/2){2'b10}}};
      foreach (directed[i]) begin
         send_value(directed[i]);
      end

      for (int n = 0; n < RANDOM_VALUES; n++) begin
         if (n == 20) no_idle <= 1'b1;
         if (n == 50) no_idle <= 1'b0;
         send_value(random_value());
      end
      req_tvalid <= 1'b0;

      // drain outstanding characters, then watch for strays
      do @(negedge clock); while (chars_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/sbda_pkg.sv
design/sbda_dp.sv
design/sbda_ctrl.sv
design/signed_binary_to_decimal_ascii.sv
design/sbda_chk.sv
dv/sbda_text_checker.sv
dv/tb_signed_binary_to_decimal_ascii.sv
